[design/assert_macros.svh]
// Assertion macros shared by the RTL. They compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every rising edge except while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, also during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)

`endif

`endif

[design/mhpq_pkg.sv]
package mhpq_pkg;

   localparam int HEAP_DEPTH = 128;
   localparam int ADDR_W     = $clog2(HEAP_DEPTH);
   localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
   localparam int IDX_W      = ADDR_W + 1;
   localparam int KEY_W      = 32;
   localparam int TOTAL_W    = 8;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_DELETE = 1'b1;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic                    req_type;
      logic signed [KEY_W-1:0] key_value;
   } mhpq_req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [KEY_W-1:0] top_value;
      logic [TOTAL_W-1:0]      element_total;
   } mhpq_rsp_type;

endpackage

[design/max_heap_priority_queue.sv]
// Binary max-heap of signed keys; one request in flight, one response beat per request.
// Insert: the key rises from the end; each parent is read and compared, and moves down
// while the key is greater. Full insert, empty delete and one-key delete go straight to the response.
// Delete-max: the last key is read and sinks from the root past the larger child per level.
// A request is accepted again once the response beat has been taken.
// Synchronous active-high reset empties the heap; memory contents are not cleared.
`include "assert_macros.svh"

module max_heap_priority_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mhpq_pkg::mhpq_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mhpq_pkg::mhpq_rsp_type rsp_data
);
   import mhpq_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DLAST = 4'd1;
   localparam logic [3:0] S_UP    = 4'd2;
   localparam logic [3:0] S_UPC   = 4'd3;
   localparam logic [3:0] S_DN    = 4'd4;
   localparam logic [3:0] S_DNL   = 4'd5;
   localparam logic [3:0] S_DNR   = 4'd6;
   localparam logic [3:0] S_DNM   = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;

   logic [3:0]              state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [ADDR_W-1:0]       pos_ff, pos_in;
   logic [ADDR_W-1:0]       best_ff, best_in;
   logic                    child_ff, child_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic signed [KEY_W-1:0] best_val_ff, best_val_in;
   logic signed [KEY_W-1:0] root_ff;
   logic [1:0]              status_ff, status_in;

   logic signed [KEY_W-1:0] heap_mem_ff [HEAP_DEPTH];
   logic signed [KEY_W-1:0] rd_data_ff;
   logic                    mem_we, mem_re;
   logic [ADDR_W-1:0]       mem_wa, mem_ra;
   logic signed [KEY_W-1:0] mem_wd;

   logic signed [KEY_W-1:0] cmp_a, cmp_b;
   logic                    cmp_gt;
   logic [ADDR_W-1:0]       parent;
   logic [IDX_W-1:0]        left, right, cnt_ext;
   logic                    accept;

   assign accept  = req_valid && !req_stall;
   assign parent  = (pos_ff - ADDR_W'(1)) >> 1;
   assign left    = {pos_ff, 1'b1};
   assign right   = left + IDX_W'(1);
   assign cnt_ext = IDX_W'(cnt_ff);

   // The one compare unit; its operands follow the sequencer state.
   always_comb begin
      unique case (state_ff)
         S_UPC: begin
            cmp_a = key_ff;
            cmp_b = rd_data_ff;
         end
         S_DNL: begin
            cmp_a = rd_data_ff;
            cmp_b = key_ff;
         end
         default: begin
            cmp_a = rd_data_ff;
            cmp_b = best_val_ff;
         end
      endcase
   end
   assign cmp_gt = cmp_a > cmp_b;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      pos_in      = pos_ff;
      best_in     = best_ff;
      child_in    = child_ff;
      key_in      = key_ff;
      best_val_in = best_val_ff;
      status_in   = status_ff;
      mem_we      = 1'b0;
      mem_wa      = pos_ff;
      mem_wd      = key_ff;
      mem_re      = 1'b0;
      mem_ra      = parent;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = ST_DONE;
               if (req_data.req_type == REQ_INSERT) begin
                  if (cnt_ff == CNT_W'(HEAP_DEPTH)) begin
                     status_in = ST_FULL;
                     state_in  = S_RESP;
                  end else begin
                     pos_in   = ADDR_W'(cnt_ff);
                     key_in   = req_data.key_value;
                     cnt_in   = cnt_ff + CNT_W'(1);
                     state_in = S_UP;
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_RESP;
                  end else begin
                     cnt_in = cnt_ff - CNT_W'(1);
                     if (cnt_ff == CNT_W'(1)) begin
                        state_in = S_RESP;
                     end else begin
                        mem_re   = 1'b1;
                        mem_ra   = ADDR_W'(cnt_ff - CNT_W'(1));
                        state_in = S_DLAST;
                     end
                  end
               end
            end
         end
         S_DLAST: begin
            key_in   = rd_data_ff;
            pos_in   = '0;
            state_in = S_DN;
         end
         S_UP: begin
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               state_in = S_RESP;
            end else begin
               mem_re   = 1'b1;
               state_in = S_UPC;
            end
         end
         S_UPC: begin
            mem_we = 1'b1;
            if (cmp_gt) begin
               // Parent moves down into the hole; the key keeps rising.
               mem_wd   = rd_data_ff;
               pos_in   = parent;
               state_in = S_UP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_DN: begin
            if (left >= cnt_ext) begin
               mem_we   = 1'b1;
               state_in = S_RESP;
            end else begin
               mem_re   = 1'b1;
               mem_ra   = ADDR_W'(left);
               state_in = S_DNL;
            end
         end
         S_DNL: begin
            if (cmp_gt) begin
               best_in     = ADDR_W'(left);
               best_val_in = rd_data_ff;
               child_in    = 1'b1;
            end else begin
               best_val_in = key_ff;
               child_in    = 1'b0;
            end
            if (right < cnt_ext) begin
               mem_re   = 1'b1;
               mem_ra   = ADDR_W'(right);
               state_in = S_DNR;
            end else begin
               state_in = S_DNM;
            end
         end
         S_DNR: begin
            // Strictly greater only, so the left child wins a tie.
            if (cmp_gt) begin
               best_in     = ADDR_W'(right);
               best_val_in = rd_data_ff;
               child_in    = 1'b1;
            end
            state_in = S_DNM;
         end
         S_DNM: begin
            mem_we = 1'b1;
            if (child_ff) begin
               mem_wd   = best_val_ff;
               pos_in   = best_ff;
               state_in = S_DN;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      best_ff     <= best_in;
      child_ff    <= child_in;
      key_ff      <= key_in;
      best_val_ff <= best_val_in;
      status_ff   <= status_in;
      if (mem_we && mem_wa == '0) begin
         root_ff <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem_ff[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= heap_mem_ff[mem_ra];
      end
   end

   assign req_stall              = (state_ff != S_IDLE);
   assign rsp_valid              = (state_ff == S_RESP);
   assign rsp_data.status        = status_ff;
   assign rsp_data.top_value     = (cnt_ff == '0) ? '0 : root_ff;
   assign rsp_data.element_total = TOTAL_W'(cnt_ff);

   `ASSERT_CLK_RST(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(HEAP_DEPTH), "count above depth")
   `ASSERT_CLK_RST(a_rsp_busy, clock, reset, rsp_valid |-> req_stall, "request taken during response")
   `ASSERT_CLK_RST(a_accept_busy, clock, reset, accept |=> req_stall, "not busy after accept")
   `ASSERT_CLK_RST(a_empty_cnt, clock, reset, (rsp_valid && rsp_data.status == ST_EMPTY) |-> (cnt_ff == '0), "empty status with nonzero count")
   `ASSERT_CLK_RST(a_write_range, clock, reset, mem_we |-> (IDX_W'(mem_wa) < cnt_ext), "heap write beyond count")
   `ASSERT_CLK(a_reset_idle, clock, reset |=> (state_ff == S_IDLE), "not idle after reset")

endmodule

[verif/tb_max_heap_priority_queue.sv]
module tb_max_heap_priority_queue;
   timeunit 1ns;
   timeprecision 1ps;

   import mhpq_pkg::*;

   localparam int DIR_ROWS     = 25;
   localparam int RAND_ITEMS   = 1650;
   localparam int IDLE_PCT     = 22;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SHOW_ERRORS  = 10;

   localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;
   localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
   localparam mhpq_rsp_type     NO_RSP  = '0;

   typedef enum int {MODE_MIX, MODE_FILL, MODE_DRAIN} traffic_mode_type;

   typedef struct packed {
      logic             op;
      logic [KEY_W-1:0] key;
      logic             has_rsp;
      mhpq_rsp_type     rsp;
   } heap_row_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   mhpq_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   mhpq_rsp_type rsp_data;

   // Quiet stretch: neither side idles while this is set.
   bit           calm = 1'b0;
   int           error_count = 0;
   int           cycle_count = 0;

   logic signed [KEY_W-1:0] heap_keys [HEAP_DEPTH];
   int                      heap_size = 0;
   mhpq_rsp_type            pending_rsp_q [$];

   // Rows with has_rsp set carry a hand-written response; all others use the shadow heap.
   heap_row_type dir_rows [DIR_ROWS] = '{
      '{REQ_DELETE, 32'h0,         1'b1, '{ST_EMPTY, 32'h0,   8'd0}},
      '{REQ_INSERT, KEY_MAX,       1'b1, '{ST_DONE,  KEY_MAX, 8'd1}},
      '{REQ_INSERT, KEY_MIN,       1'b1, '{ST_DONE,  KEY_MAX, 8'd2}},
      '{REQ_DELETE, 32'h0,         1'b1, '{ST_DONE,  KEY_MIN, 8'd1}},
      '{REQ_DELETE, 32'h0,         1'b1, '{ST_DONE,  32'h0,   8'd0}},
      '{REQ_DELETE, 32'hffff_ffff, 1'b1, '{ST_EMPTY, 32'h0,   8'd0}},
      '{REQ_INSERT, 32'hffff_ffff, 1'b0, NO_RSP},
      '{REQ_INSERT, 32'd5,         1'b0, NO_RSP},
      '{REQ_INSERT, 32'd5,         1'b0, NO_RSP},
      '{REQ_INSERT, 32'd5,         1'b0, NO_RSP},
      '{REQ_INSERT, 32'd3,         1'b0, NO_RSP},
      '{REQ_INSERT, 32'd7,         1'b0, NO_RSP},
      '{REQ_INSERT, KEY_MIN,       1'b0, NO_RSP},
      '{REQ_INSERT, KEY_MAX,       1'b0, NO_RSP},
      '{REQ_DELETE, 32'hffff_ffff, 1'b0, NO_RSP},
      '{REQ_DELETE, 32'h5555_aaaa, 1'b0, NO_RSP},
      '{REQ_DELETE, 32'h0,         1'b0, NO_RSP},
      '{REQ_DELETE, 32'h0,         1'b0, NO_RSP},
      '{REQ_INSERT, 32'h0,         1'b0, NO_RSP},
      '{REQ_DELETE, 32'h0,         1'b0, NO_RSP},
      '{REQ_DELETE, 32'h0,         1'b0, NO_RSP},
      '{REQ_DELETE, 32'h0,         1'b0, NO_RSP},
      '{REQ_DELETE, 32'h0,         1'b0, NO_RSP},
      '{REQ_DELETE, 32'h0,         1'b0, NO_RSP},
      '{REQ_DELETE, 32'h0,         1'b1, '{ST_EMPTY, 32'h0,   8'd0}}
   };

   max_heap_priority_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic bit take_break();
      return !calm && ($urandom_range(99) < IDLE_PCT);
   endfunction

   // Applies one request to the shadow heap and returns the response it should produce.
   function automatic mhpq_rsp_type heap_apply(mhpq_req_type r);
      mhpq_rsp_type            res;
      int                      pos;
      int                      up;
      int                      best;
      int                      kid;
      logic signed [KEY_W-1:0] tmp;
      res.status = ST_DONE;
      if (r.req_type == REQ_INSERT) begin
         if (heap_size >= HEAP_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            pos = heap_size;
            heap_keys[pos] = r.key_value;
            heap_size++;
            while (pos > 0 && heap_keys[pos] > heap_keys[(pos - 1) / 2]) begin
               up = (pos - 1) / 2;
               tmp = heap_keys[pos];
               heap_keys[pos] = heap_keys[up];
               heap_keys[up] = tmp;
               pos = up;
            end
         end
      end else if (heap_size == 0) begin
         res.status = ST_EMPTY;
      end else begin
         heap_size--;
         heap_keys[0] = heap_keys[heap_size];
         pos = 0;
         forever begin
            best = pos;
            // The left child is tried first, so it wins a tie with the right one.
            for (kid = 2 * pos + 1; kid <= 2 * pos + 2; kid++) begin
               if (kid < heap_size && heap_keys[kid] > heap_keys[best]) best = kid;
            end
            if (best == pos) break;
            tmp = heap_keys[pos];
            heap_keys[pos] = heap_keys[best];
            heap_keys[best] = tmp;
            pos = best;
         end
      end
      res.top_value = (heap_size > 0) ? heap_keys[0] : '0;
      res.element_total = TOTAL_W'(heap_size);
      return res;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      int sel = $urandom_range(99);
      if (sel < 20) begin
         // Narrow range so that equal keys and ties between children are common.
         return KEY_W'($urandom_range(6)) - KEY_W'(3);
      end else if (sel < 30) begin
         case ($urandom_range(3))
            0: return KEY_MAX;
            1: return KEY_MIN;
            2: return '0;
            default: return '1;
         endcase
      end
      return $urandom;
   endfunction

   // Entered and left at a falling edge; valid stays high when beats follow back to back.
   task automatic send_beat(input logic op, input logic [KEY_W-1:0] key, input bit has_rsp,
                            input mhpq_rsp_type fixed_rsp, output mhpq_rsp_type predicted);
      mhpq_req_type r;
      r.req_type = op;
      r.key_value = key;
      while (take_break()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      predicted = heap_apply(r);
      pending_rsp_q.push_back(has_rsp ? fixed_rsp : predicted);
      @(negedge clock);
   endtask

   task automatic report_mismatch(input string what, input mhpq_rsp_type want,
                                  input mhpq_rsp_type got);
      error_count++;
      if (error_count <= SHOW_ERRORS)
         $display("%0t %s: expected status %0d top %0d total %0d, got status %0d top %0d total %0d",
                  $realtime, what, want.status, want.top_value, want.element_total,
                  got.status, got.top_value, got.element_total);
   endtask

   always @(negedge clock) begin
      rsp_stall <= !reset && take_break();
   end

   always @(posedge clock) begin
      mhpq_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("response beat with nothing outstanding", NO_RSP, rsp_data);
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_data.status !== want.status || rsp_data.top_value !== want.top_value ||
                rsp_data.element_total !== want.element_total)
               report_mismatch("response mismatch", want, rsp_data);
         end
      end
   end

   initial begin
      mhpq_rsp_type     seen;
      traffic_mode_type mode;
      int               sent;
      int               seg;
      int               seg_len;
      int               ins_pct;
      logic             op;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         send_beat(dir_rows[i].op, dir_rows[i].key, dir_rows[i].has_rsp, dir_rows[i].rsp,
                   seen);

      // Fill and drain bursts drive the heap to both ends; mixed bursts churn the middle.
      sent = 0;
      seg = 0;
      while (sent < RAND_ITEMS) begin
         mode = (seg == 0) ? MODE_FILL : traffic_mode_type'($urandom_range(2));
         seg_len = (seg == 0) ? 150 : (mode == MODE_MIX) ? $urandom_range(20, 120)
                                                        : $urandom_range(60, 180);
         ins_pct = (mode == MODE_FILL) ? 93 : (mode == MODE_DRAIN) ? 7 : 55;
         for (int j = 0; j < seg_len && sent < RAND_ITEMS; j++) begin
            calm <= (sent >= 700 && sent < 1000);
            op = ($urandom_range(99) < ins_pct) ? REQ_INSERT : REQ_DELETE;
            send_beat(op, pick_key(), 1'b0, NO_RSP, seen);
            sent++;
         end
         seg++;
      end
      req_valid <= 1'b0;
      calm <= 1'b0;

      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/mhpq_pkg.sv
design/max_heap_priority_queue.sv
verif/tb_max_heap_priority_queue.sv
